// File: design/cps_pkg.sv
// Shared constants, types and helpers for the content pattern scanner.
package cps_pkg;

  localparam int unsigned WIN_DEPTH    = 67;
  localparam int unsigned SPAN         = WIN_DEPTH + 1;
  localparam int unsigned SCRIPT_COUNT = 33;
  // longest script pattern, in bytes
  localparam int unsigned DANGER_SPAN  = 18;

  localparam logic [1:0] CFG_EICAR_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_SCRIPT_ENABLE  = 2'd1;
  localparam logic [1:0] CFG_MAX_SCAN_BYTES = 2'd2;

  localparam logic [31:0] MAX_SCAN_RESET = 32'd16777216;

  typedef enum logic [2:0] {
    SEV_INFO     = 3'd0,
    SEV_LOW      = 3'd1,
    SEV_MEDIUM   = 3'd2,
    SEV_HIGH     = 3'd3,
    SEV_CRITICAL = 3'd4
  } severity_t;

  typedef enum logic [1:0] {
    VERDICT_CLEAN      = 2'd0,
    VERDICT_SUSPICIOUS = 2'd1,
    VERDICT_MALICIOUS  = 2'd2
  } verdict_t;

  typedef struct packed {
    logic                    eicar;
    logic [SCRIPT_COUNT-1:0] danger;
  } hits_t;

  // Oldest character sits in the top byte.
  localparam logic [SPAN*8-1:0] EICAR_TEXT =
    "X5O!P%@AP[4\\PZX54(P^)7CC)7}$EICAR-STANDARD-ANTIVIRUS-TEST-FILE!$H+H*";

  // Right-aligned, zero padded on the left; a zero byte is a don't-care.
  localparam logic [DANGER_SPAN*8-1:0] DANGER_TEXT [SCRIPT_COUNT] = '{
    "rm -rf",             "mkfs.",
    ":(){ :|:& };:",      "format c:",
    "reg delete",         "bcdedit",
    "os.execute",         "io.popen",
    "loadstring(",        "os.system",
    "subprocess",         "invoke-expression",
    "downloadstring",     "downloadfile(",
    "certutil -urlcache", "certutil -decode",
    "bitsadmin",          "mshta ",
    "wscript.shell",      "shell.application",
    "powershell",         "-encodedcommand",
    "cmd.exe",            "reg add",
    "virtualalloc",       "createremotethread",
    "writeprocessmemory", "eval(",
    "exec(",              "__import__",
    "createobject(",      "dofile(",
    "base64"
  };

  localparam severity_t DANGER_SEV [SCRIPT_COUNT] = '{
    SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,
    SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_MEDIUM, SEV_HIGH,
    SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,
    SEV_HIGH,   SEV_HIGH,   SEV_MEDIUM, SEV_HIGH,   SEV_MEDIUM, SEV_MEDIUM,
    SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_MEDIUM, SEV_MEDIUM, SEV_MEDIUM,
    SEV_MEDIUM, SEV_MEDIUM, SEV_LOW
  };

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    lower_ascii = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

// File: design/cps_byte_if.sv
// Content byte channel: valid/ready with one byte and a last flag.
interface cps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;
  logic       last_byte;

  modport source (output valid, output scan_byte, output last_byte, input ready);
  modport sink   (input valid, input scan_byte, input last_byte, output ready);
endinterface

// File: design/cps_result_if.sv
// Scan result channel: valid/ready with the per-content report.
interface cps_result_if;
  logic                              valid;
  logic                              ready;
  logic [cps_pkg::SCRIPT_COUNT-1:0]  script_hit_mask;
  logic                              eicar_found;
  logic                              oversize;
  logic [2:0]                        worst_severity;
  logic [1:0]                        verdict;

  modport source (output valid, output script_hit_mask, output eicar_found,
                  output oversize, output worst_severity, output verdict,
                  input ready);
  modport sink   (input valid, input script_hit_mask, input eicar_found,
                  input oversize, input worst_severity, input verdict,
                  output ready);
endinterface

// File: design/cps_matcher.sv
// Parallel comparators: EICAR string and script patterns ending at the newest byte.
module cps_matcher (
  input  logic [7:0]    span [cps_pkg::SPAN],
  output cps_pkg::hits_t hits
);

  logic [7:0] folded [cps_pkg::SPAN];

  always_comb begin
    for (int j = 0; j < cps_pkg::SPAN; j++) begin
      folded[j] = cps_pkg::lower_ascii(span[j]);
    end
  end

  always_comb begin
    logic [7:0] pb;
    logic       ok;
    hits.eicar = 1'b1;
    for (int j = 0; j < cps_pkg::SPAN; j++) begin
      if (span[j] != cps_pkg::EICAR_TEXT[(cps_pkg::SPAN-1-j)*8 +: 8]) begin
        hits.eicar = 1'b0;
      end
    end
    for (int k = 0; k < cps_pkg::SCRIPT_COUNT; k++) begin
      ok = 1'b1;
      for (int j = 0; j < cps_pkg::DANGER_SPAN; j++) begin
        pb = cps_pkg::DANGER_TEXT[k][(cps_pkg::DANGER_SPAN-1-j)*8 +: 8];
        if (pb != 8'd0 && pb != folded[cps_pkg::SPAN-cps_pkg::DANGER_SPAN+j]) begin
          ok = 1'b0;
        end
      end
      hits.danger[k] = ok;
    end
  end

endmodule

// File: design/content_pattern_scanner_unit.sv
// Content pattern scanner top level: window, hit collection and result register.
//
//   channel  | dir | payload                                        | rule
//   content  | in  | scan_byte, last_byte                           | valid & ready
//   report   | out | script_hit_mask, eicar_found, oversize,        | valid & ready
//            |     | worst_severity, verdict                        |
//   cfg      | in  | cfg_index, cfg_data                            | cfg_we
//
// One byte per cycle while no last byte is held (see below). A byte is registered on input
// and matched against the 67-byte window in the next cycle; a last byte's report is loaded
// into the output register as that byte leaves the input register. Reset (rst,
// synchronous) clears window and counters and restores enables and scan limit.
// A last byte waits in the input register only while an unread report is held and
// not taken; other bytes flow through.
module content_pattern_scanner_unit (
  input  logic                clk,
  input  logic                rst,
  cps_byte_if.sink            content,
  cps_result_if.source        report,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  logic        eicar_enable;
  logic        script_enable;
  logic [31:0] max_scan_bytes;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_adv;
  logic        step;

  logic [7:0]                       win [cps_pkg::WIN_DEPTH];
  logic [7:0]                       span [cps_pkg::SPAN];
  logic [31:0]                      bytes_counted;
  logic [31:0]                      bytes_counted_next;
  logic [cps_pkg::SCRIPT_COUNT-1:0] pattern_seen;
  logic [cps_pkg::SCRIPT_COUNT-1:0] pattern_seen_next;
  logic                             test_string_seen;
  logic                             test_string_seen_next;
  logic                             in_scope;
  cps_pkg::hits_t                   hits;

  logic [cps_pkg::SCRIPT_COUNT-1:0] mask;
  logic                             eic;
  cps_pkg::severity_t               worst;
  cps_pkg::verdict_t                verdict;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      eicar_enable   <= 1'b1;
      script_enable  <= 1'b0;
      max_scan_bytes <= cps_pkg::MAX_SCAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cps_pkg::CFG_EICAR_ENABLE:   eicar_enable   <= cfg_data[0];
        cps_pkg::CFG_SCRIPT_ENABLE:  script_enable  <= cfg_data[0];
        cps_pkg::CFG_MAX_SCAN_BYTES: max_scan_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  assign s1_adv        = !(s1_last && report.valid && !report.ready);
  assign step          = s1_valid && s1_adv;
  assign content.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (content.ready) begin
      s1_valid <= content.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (content.ready && content.valid) begin
      s1_byte <= content.scan_byte;
      s1_last <= content.last_byte;
    end
  end

  // match
  always_comb begin
    for (int j = 0; j < cps_pkg::WIN_DEPTH; j++) begin
      span[j] = win[j];
    end
    span[cps_pkg::WIN_DEPTH] = s1_byte;
  end

  cps_matcher u_matcher (
    .span (span),
    .hits (hits)
  );

  assign in_scope              = bytes_counted < max_scan_bytes;
  assign bytes_counted_next    = (&bytes_counted) ? bytes_counted : bytes_counted + 32'd1;
  assign pattern_seen_next     = pattern_seen | (in_scope ? hits.danger : '0);
  assign test_string_seen_next = test_string_seen | (in_scope & hits.eicar);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_counted    <= '0;
      pattern_seen     <= '0;
      test_string_seen <= 1'b0;
      for (int j = 0; j < cps_pkg::WIN_DEPTH; j++) begin
        win[j] <= 8'd0;
      end
    end else if (step) begin
      if (s1_last) begin
        bytes_counted    <= '0;
        pattern_seen     <= '0;
        test_string_seen <= 1'b0;
        for (int j = 0; j < cps_pkg::WIN_DEPTH; j++) begin
          win[j] <= 8'd0;
        end
      end else begin
        bytes_counted    <= bytes_counted_next;
        pattern_seen     <= pattern_seen_next;
        test_string_seen <= test_string_seen_next;
        if (in_scope) begin
          for (int j = 0; j < cps_pkg::WIN_DEPTH; j++) begin
            win[j] <= span[j+1];
          end
        end
      end
    end
  end

  // report
  always_comb begin
    logic any_high;
    logic any_med;
    logic any_low;
    any_high = 1'b0;
    any_med  = 1'b0;
    any_low  = 1'b0;
    mask = script_enable ? pattern_seen_next : '0;
    eic  = eicar_enable & test_string_seen_next;
    for (int k = 0; k < cps_pkg::SCRIPT_COUNT; k++) begin
      if (mask[k] && cps_pkg::DANGER_SEV[k] == cps_pkg::SEV_HIGH)   any_high = 1'b1;
      if (mask[k] && cps_pkg::DANGER_SEV[k] == cps_pkg::SEV_MEDIUM) any_med  = 1'b1;
      if (mask[k] && cps_pkg::DANGER_SEV[k] == cps_pkg::SEV_LOW)    any_low  = 1'b1;
    end
    if (eic)           worst = cps_pkg::SEV_CRITICAL;
    else if (any_high) worst = cps_pkg::SEV_HIGH;
    else if (any_med)  worst = cps_pkg::SEV_MEDIUM;
    else if (any_low)  worst = cps_pkg::SEV_LOW;
    else               worst = cps_pkg::SEV_INFO;
    if (eic)                              verdict = cps_pkg::VERDICT_MALICIOUS;
    else if (worst >= cps_pkg::SEV_MEDIUM) verdict = cps_pkg::VERDICT_SUSPICIOUS;
    else                                  verdict = cps_pkg::VERDICT_CLEAN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (step && s1_last) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last) begin
      report.script_hit_mask <= mask;
      report.eicar_found     <= eic;
      report.oversize        <= bytes_counted_next > max_scan_bytes;
      report.worst_severity  <= worst;
      report.verdict         <= verdict;
    end
  end

endmodule

// File: tb/sv/cps_report_checker.sv
// Report checker: tracks content items, predicts each scan report and compares it.
module cps_report_checker
  import cps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cps_byte_if         content,
  cps_result_if       report,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SCRIPT_COUNT-1:0] hits;
    logic                    eicar;
    logic                    oversize;
    severity_t               worst;
    verdict_t                verdict;
  } scan_report_t;

  string eicar_text =
    "X5O!P%@AP[4\\PZX54(P^)7CC)7}$EICAR-STANDARD-ANTIVIRUS-TEST-FILE!$H+H*";

  string danger_text [SCRIPT_COUNT] = '{
    "rm -rf", "mkfs.", ":(){ :|:& };:", "format c:", "reg delete", "bcdedit",
    "os.execute", "io.popen", "loadstring(", "os.system", "subprocess",
    "invoke-expression", "downloadstring", "downloadfile(", "certutil -urlcache",
    "certutil -decode", "bitsadmin", "mshta ", "wscript.shell", "shell.application",
    "powershell", "-encodedcommand", "cmd.exe", "reg add", "virtualalloc",
    "createremotethread", "writeprocessmemory", "eval(", "exec(", "__import__",
    "createobject(", "dofile(", "base64"
  };

  severity_t danger_level [SCRIPT_COUNT] = '{
    SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,
    SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_MEDIUM, SEV_HIGH,
    SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_HIGH,
    SEV_HIGH,   SEV_HIGH,   SEV_MEDIUM, SEV_HIGH,   SEV_MEDIUM, SEV_MEDIUM,
    SEV_HIGH,   SEV_HIGH,   SEV_HIGH,   SEV_MEDIUM, SEV_MEDIUM, SEV_MEDIUM,
    SEV_MEDIUM, SEV_MEDIUM, SEV_LOW
  };

  // shadow registers
  logic        eicar_on;
  logic        script_on;
  logic [31:0] scan_limit;

  // per-content state; history[0] is the oldest byte
  logic [7:0]              history [WIN_DEPTH];
  logic [7:0]              span [SPAN];
  logic [31:0]             seen_count;
  logic [SCRIPT_COUNT-1:0] danger_seen;
  logic                    eicar_seen;

  scan_report_t pending_reports [$];
  int unsigned  miss_count = 0;
  int unsigned  report_no = 0;

  function automatic bit tail_matches(input string pat, input bit fold);
    int n;
    int i;
    logic [7:0] c;
    n = pat.len();
    for (i = 0; i < n; i++) begin
      c = span[SPAN - n + i];
      if (fold && c >= 8'h41 && c <= 8'h5A) c = c + 8'd32;
      if (c != pat[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_content();
    int i;
    for (i = 0; i < WIN_DEPTH; i++) history[i] = 8'h00;
    seen_count  = '0;
    danger_seen = '0;
    eicar_seen  = 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("report %0d: %s got 0x%0h, expected 0x%0h", report_no, what, got, want);
    miss_count++;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    scan_report_t r;
    int k;
    if (seen_count < scan_limit) begin
      for (k = 0; k < WIN_DEPTH; k++) span[k] = history[k];
      span[WIN_DEPTH] = b;
      if (tail_matches(eicar_text, 1'b0)) eicar_seen = 1'b1;
      for (k = 0; k < SCRIPT_COUNT; k++)
        if (tail_matches(danger_text[k], 1'b1)) danger_seen[k] = 1'b1;
      for (k = 0; k < WIN_DEPTH; k++) history[k] = span[k + 1];
    end
    if (seen_count != 32'hFFFF_FFFF) seen_count++;
    if (fin) begin
      r.hits     = script_on ? danger_seen : '0;
      r.eicar    = eicar_on & eicar_seen;
      r.oversize = seen_count > scan_limit;
      r.worst    = SEV_INFO;
      for (k = 0; k < SCRIPT_COUNT; k++)
        if (r.hits[k] && danger_level[k] > r.worst) r.worst = danger_level[k];
      if (r.eicar) begin
        r.worst   = SEV_CRITICAL;
        r.verdict = VERDICT_MALICIOUS;
      end else if (r.worst >= SEV_MEDIUM) begin
        r.verdict = VERDICT_SUSPICIOUS;
      end else begin
        r.verdict = VERDICT_CLEAN;
      end
      pending_reports = {pending_reports, r};
      clear_content();
    end
  endtask

  task automatic check_report();
    scan_report_t want;
    if (pending_reports.size() == 0) begin
      flag_mismatch("unexpected report", report.script_hit_mask, '0);
    end else begin
      want = pending_reports.pop_front();
      if (report.script_hit_mask !== want.hits)
        flag_mismatch("script_hit_mask", report.script_hit_mask, want.hits);
      if (report.eicar_found !== want.eicar)
        flag_mismatch("eicar_found", report.eicar_found, want.eicar);
      if (report.oversize !== want.oversize)
        flag_mismatch("oversize", report.oversize, want.oversize);
      if (report.worst_severity !== want.worst)
        flag_mismatch("worst_severity", report.worst_severity, want.worst);
      if (report.verdict !== want.verdict)
        flag_mismatch("verdict", report.verdict, want.verdict);
    end
    report_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      eicar_on   = 1'b1;
      script_on  = 1'b0;
      scan_limit = MAX_SCAN_RESET;
      clear_content();
      pending_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_EICAR_ENABLE:   eicar_on = cfg_data[0];
          CFG_SCRIPT_ENABLE:  script_on = cfg_data[0];
          CFG_MAX_SCAN_BYTES: scan_limit = cfg_data;
          default: ;
        endcase
      end
      // a report taken now always belongs to an older item
      if (report.valid && report.ready) check_report();
      if (content.valid && content.ready) absorb_byte(content.scan_byte, content.last_byte);
    end
    mismatches  <= miss_count;
    outstanding <= pending_reports.size();
  end

endmodule

// File: tb/sv/content_pattern_scanner_unit_tb.sv
// Testbench top: content stimulus, report pacing, watchdog and final verdict.
module content_pattern_scanner_unit_tb;
  import cps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1130;
  localparam int PHASE_BYTES  = 225;
  localparam int CHOKE_CYCLES = 500;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 4;

  typedef enum logic [1:0] {AS_IS, MIXED_CASE, CORRUPTED, TRUNCATED} shape_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int unsigned mismatches;
  int unsigned outstanding;

  cps_byte_if   content();
  cps_result_if report();

  content_pattern_scanner_unit dut (
    .clk       (clk),
    .rst       (rst),
    .content   (content),
    .report    (report),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cps_report_checker chk (
    .clk         (clk),
    .rst         (rst),
    .content     (content),
    .report      (report),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  logic [7:0]  bytes_q [$];
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  logic        choke_req = 1'b0;
  logic        cur_eicar;
  logic        cur_script;
  logic [31:0] cur_limit;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // report side: runs of different ready patterns, plus one long hold-off on request
  initial begin : sink_pacing
    int mode;
    int run;
    bit choked;
    choked = 1'b0;
    report.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (choke_req && !choked) begin
        report.ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
        choked = 1'b1;
      end
      mode = $urandom_range(0, 3);
      run  = $urandom_range(1, 40);
      repeat (run) begin
        case (mode)
          0: report.ready <= 1'b1;
          1: report.ready <= $urandom_range(0, 1);
          2: report.ready <= ($urandom_range(0, 7) != 0);
          default: report.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (content.valid && content.ready) || (report.valid && report.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[content_pattern_scanner_unit] ERROR");
      $finish;
    end
  end

  task automatic put_item(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        content.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    content.valid     <= 1'b1;
    content.scan_byte <= b;
    content.last_byte <= fin;
    @(posedge clk);
    while (!content.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // close = 0 leaves the content open for a later item
  task automatic send_content(input bit close);
    int i;
    for (i = 0; i < bytes_q.size(); i++)
      put_item(bytes_q[i], close && (i == bytes_q.size() - 1));
    bytes_q.delete();
  endtask

  // wait until every report is in and the pipeline holds no stray byte
  task automatic settle();
    content.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic en_eicar, input logic en_script,
                             input logic [31:0] limit);
    logic [31:0] junk;
    junk = $urandom();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EICAR_ENABLE;
    cfg_data  <= {junk[31:1], en_eicar};
    @(posedge clk);
    junk = $urandom();
    cfg_index <= CFG_SCRIPT_ENABLE;
    cfg_data  <= {junk[31:1], en_script};
    @(posedge clk);
    cfg_index <= CFG_MAX_SCAN_BYTES;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_eicar  = en_eicar;
    cur_script = en_script;
    cur_limit  = limit;
  endtask

  task automatic append_byte(input logic [7:0] b);
    bytes_q = {bytes_q, b};
  endtask

  task automatic add_ascii(input string s);
    int i;
    for (i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task automatic add_noise(input int n, input bit letters);
    logic [7:0] c;
    repeat (n) begin
      if (letters) c = $urandom_range(8'h61, 8'h7A) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
      else         c = $urandom_range(0, 255);
      append_byte(c);
    end
  endtask

  // text is right aligned with zero padding on the left
  task automatic add_pattern(input logic [SPAN*8-1:0] text, input shape_t shape);
    logic [7:0] piece [$];
    logic [7:0] c;
    int i;
    for (i = SPAN - 1; i >= 0; i--) begin
      c = text[i*8 +: 8];
      if (c != 8'h00) begin
        if (shape != AS_IS && ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
            && $urandom_range(0, 1) == 1)
          c = c ^ 8'h20;
        piece = {piece, c};
      end
    end
    if (shape == CORRUPTED) piece[$urandom_range(0, piece.size() - 1)] = $urandom_range(0, 255);
    if (shape == TRUNCATED) void'(piece.pop_back());
    for (i = 0; i < piece.size(); i++) append_byte(piece[i]);
  endtask

  task automatic build_random();
    int pieces;
    pieces = $urandom_range(1, 4);
    repeat (pieces) begin
      case ($urandom_range(0, 11))
        0, 1:       add_noise($urandom_range(1, 10), 1'b0);
        2, 3, 4, 5: add_pattern(DANGER_TEXT[$urandom_range(0, SCRIPT_COUNT - 1)], MIXED_CASE);
        6:          add_pattern(DANGER_TEXT[$urandom_range(0, SCRIPT_COUNT - 1)], AS_IS);
        7:          add_pattern(DANGER_TEXT[$urandom_range(0, SCRIPT_COUNT - 1)], CORRUPTED);
        8:          add_pattern(DANGER_TEXT[$urandom_range(0, SCRIPT_COUNT - 1)], TRUNCATED);
        9:          add_pattern(EICAR_TEXT, ($urandom_range(0, 2) == 0) ? CORRUPTED : AS_IS);
        default:    add_noise($urandom_range(1, 8), 1'b1);
      endcase
    end
  endtask

  initial begin : stimulus
    int k;
    int phase;
    int base;
    int phase_end;
    logic [31:0] limit;
    rst               = 1'b1;
    content.valid     = 1'b0;
    content.scan_byte = 8'h00;
    content.last_byte = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_EICAR_ENABLE;
    cfg_data          = '0;
    cur_eicar         = 1'b1;
    cur_script        = 1'b0;
    cur_limit         = MAX_SCAN_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: EICAR on, script scan off
    append_byte(8'h00);
    send_content(1);
    append_byte(8'hFF);
    send_content(1);
    add_pattern(EICAR_TEXT, AS_IS);
    send_content(1);
    add_ascii("rm -rf");
    send_content(1);
    settle();

    load_config(1'b1, 1'b1, MAX_SCAN_RESET);
    for (k = 0; k < SCRIPT_COUNT; k++) begin
      add_pattern(DANGER_TEXT[k], MIXED_CASE);
      append_byte(8'h20);
    end
    send_content(1);
    add_ascii("BASE64");
    send_content(1);
    add_ascii("xSubProcess");
    send_content(1);
    // a pattern split over two contents must not hit
    add_ascii("x rm -");
    send_content(1);
    add_ascii("rf");
    send_content(1);
    add_pattern(EICAR_TEXT, AS_IS);
    bytes_q[$] = 8'h68;
    send_content(1);
    add_pattern(EICAR_TEXT, AS_IS);
    add_ascii("PowerShell");
    send_content(1);

    // enables are sampled only when the report is formed
    add_ascii("eval(");
    send_content(0);
    settle();
    load_config(1'b1, 1'b0, cur_limit);
    add_ascii("z");
    send_content(1);
    add_ascii("exec(");
    send_content(0);
    settle();
    load_config(1'b1, 1'b1, cur_limit);
    add_ascii("z");
    send_content(1);
    settle();

    load_config(1'b0, 1'b1, 32'd0);
    add_ascii("rm -rf");
    send_content(1);
    settle();
    load_config(1'b0, 1'b1, 32'd6);
    add_ascii("rm -rf");
    send_content(1);
    add_pattern(EICAR_TEXT, AS_IS);
    send_content(1);
    settle();
    load_config(1'b1, 1'b1, 32'd5);
    add_ascii("rm -rf");
    send_content(1);
    settle();
    load_config(1'b1, 1'b1, 32'hFFFF_FFFF);
    add_ascii("CertUtil -URLCache");
    add_pattern(EICAR_TEXT, AS_IS);
    send_content(1);

    base = bytes_sent;
    for (phase = 0; bytes_sent - base < RANDOM_BYTES; phase++) begin
      settle();
      case ($urandom_range(0, 7))
        0:       limit = 32'd0;
        1:       limit = 32'd1;
        2, 3:    limit = $urandom_range(2, 90);
        4:       limit = 32'hFFFF_FFFF;
        5:       limit = $urandom();
        default: limit = MAX_SCAN_RESET;
      endcase
      load_config($urandom_range(0, 3) != 0, $urandom_range(0, 4) != 0, limit);
      // long report hold-off while items keep coming
      if (phase == 1) choke_req <= 1'b1;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        build_random();
        send_content(1);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("[content_pattern_scanner_unit] OK");
    else
      $display("[content_pattern_scanner_unit] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
design/cps_pkg.sv
design/cps_byte_if.sv
design/cps_result_if.sv
design/cps_matcher.sv
design/content_pattern_scanner_unit.sv
tb/sv/cps_report_checker.sv
tb/sv/content_pattern_scanner_unit_tb.sv
